// ----- src/sgrc_pkg.sv -----
// ----------------------------------------------------------------------------
// sgrc_pkg
// shared constants and types for the seeded group reachability counter
// ----------------------------------------------------------------------------
package sgrc_pkg;

  // default sizes
  localparam int unsigned MAX_PEOPLE = 64;
  localparam int unsigned MAX_GROUPS = 64;

  // fixed field widths
  localparam int unsigned OpW      = 2;
  localparam int unsigned MembersW = 64;
  localparam int unsigned UntouchW = 7;

  // operation codes
  localparam logic [OpW-1:0] OP_SEED   = 2'd0;
  localparam logic [OpW-1:0] OP_GROUP  = 2'd1;
  localparam logic [OpW-1:0] OP_FINISH = 2'd2;

  // sequencer states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_SWEEP = 2'b10
  } state_e;

endpackage

// ----- src/sgrc_group_mem.sv -----
// ----------------------------------------------------------------------------
// sgrc_group_mem
// group mask store, one write and one registered read port
// ----------------------------------------------------------------------------
module sgrc_group_mem #(
  parameter int unsigned Depth = sgrc_pkg::MAX_GROUPS,
  parameter int unsigned Width = sgrc_pkg::MAX_PEOPLE,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  import sgrc_pkg::*;

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/sgrc_merge_unit.sv -----
// ----------------------------------------------------------------------------
// sgrc_merge_unit
// overlap test of one group against the known set, and the merged set
// ----------------------------------------------------------------------------
module sgrc_merge_unit #(
  parameter int unsigned Width = sgrc_pkg::MAX_PEOPLE
) (
  input  logic             live_i,
  input  logic [Width-1:0] known_i,
  input  logic [Width-1:0] group_i,
  output logic             hit_o,
  output logic [Width-1:0] merged_o
);
  import sgrc_pkg::*;

  // a live group touching a known person is absorbed
  assign hit_o    = live_i & (|(known_i & group_i));
  assign merged_o = known_i | group_i;

endmodule

// ----- src/seeded_group_reachability_count.sv -----
// ----------------------------------------------------------------------------
// seeded_group_reachability_count
// counts stored groups not reachable from the seeded people
// ----------------------------------------------------------------------------
// seed and group words are taken one per cycle while no sweep runs, and take effect at once
// finish word: repeated passes over the N stored groups until a pass retires nothing,
//   at most N+1 passes, reported at once if N = 0
// the pass length is set by the single read port of the group store
// the result sits in an output register; seed/group words still flow then
// rst_ni clears known set, live flags, group count, overflow and result valid
module seeded_group_reachability_count #(
  parameter int unsigned MaxPeople = sgrc_pkg::MAX_PEOPLE,
  parameter int unsigned MaxGroups = sgrc_pkg::MAX_GROUPS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sgrc_pkg::OpW-1:0]        in_op_i,
  input  logic [sgrc_pkg::MembersW-1:0]   in_members_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sgrc_pkg::UntouchW-1:0]   out_untouched_groups_o,
  output logic                            out_overflow_o
);
  import sgrc_pkg::*;

  localparam int unsigned AddrW = (MaxGroups > 1) ? $clog2(MaxGroups) : 1;
  localparam int unsigned CntW  = $clog2(MaxGroups + 1);

  // sequencer and bookkeeping state
  state_e                state_q, state_d;
  logic [MaxPeople-1:0]  known_q, known_d;
  logic [MaxGroups-1:0]  live_q, live_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  ovf_q, ovf_d;

  // sweep pipeline: issue index, then check stage in the cycle after
  logic [CntW-1:0]       idx_q, idx_d;
  logic                  chk_vld_q, chk_vld_d;
  logic [AddrW-1:0]      chk_idx_q, chk_idx_d;
  logic                  changed_q, changed_d;
  logic [CntW-1:0]       left_q, left_d;

  // result register
  logic                  out_valid_q, out_valid_d;
  logic [UntouchW-1:0]   untouched_q, untouched_d;
  logic                  out_ovf_q, out_ovf_d;

  // memory and merge unit hookup
  logic                  mem_we, mem_re;
  logic [AddrW-1:0]      mem_waddr, mem_raddr;
  logic [MaxPeople-1:0]  mem_rdata;
  logic                  hit;
  logic [MaxPeople-1:0]  merged;

  logic                  in_acc;
  logic [MaxPeople-1:0]  in_mask;
  logic                  pass_end;
  logic                  chk_live;

  assign in_mask = in_members_i[MaxPeople-1:0];

  // a finish word waits while an earlier result is still pending
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && (in_op_i == OP_FINISH));
  assign in_acc     = in_valid_i && !in_stall_o;

  assign chk_live = live_q[chk_idx_q];

  sgrc_group_mem #(
    .Depth (MaxGroups),
    .Width (MaxPeople),
    .AddrW (AddrW)
  ) u_group_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_mask),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sgrc_merge_unit #(
    .Width (MaxPeople)
  ) u_merge_unit (
    .live_i   (chk_live),
    .known_i  (known_q),
    .group_i  (mem_rdata),
    .hit_o    (hit),
    .merged_o (merged)
  );

  // last entry of the pass is in the check stage
  assign pass_end = chk_vld_q && (CntW'(chk_idx_q) == (count_q - CntW'(1)));

  assign mem_waddr = count_q[AddrW-1:0];
  assign mem_raddr = idx_q[AddrW-1:0];

  always_comb begin
    state_d     = state_q;
    known_d     = known_q;
    live_d      = live_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    idx_d       = idx_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = chk_idx_q;
    changed_d   = changed_q;
    left_d      = left_q;
    out_valid_d = out_valid_q;
    untouched_d = untouched_q;
    out_ovf_d   = out_ovf_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    // result word leaves
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_op_i)
            OP_SEED: begin
              known_d = known_q | in_mask;
            end
            OP_GROUP: begin
              if (count_q < CntW'(MaxGroups)) begin
                mem_we                       = 1'b1;
                live_d[count_q[AddrW-1:0]]   = 1'b1;
                count_d                      = count_q + CntW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_FINISH: begin
              if (count_q == '0) begin
                // nothing stored: report at once
                out_valid_d = 1'b1;
                untouched_d = '0;
                out_ovf_d   = ovf_q;
                known_d     = '0;
              end else begin
                state_d   = ST_SWEEP;
                idx_d     = '0;
                changed_d = 1'b0;
                left_d    = '0;
              end
            end
            default: begin
              // unused code, dropped
            end
          endcase
        end
      end

      ST_SWEEP: begin
        // issue stage
        if (idx_q < count_q) begin
          mem_re    = 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = idx_q[AddrW-1:0];
          idx_d     = idx_q + CntW'(1);
        end

        // check stage, sees known set with all earlier merges applied
        if (chk_vld_q) begin
          if (hit) begin
            known_d           = merged;
            live_d[chk_idx_q] = 1'b0;
            changed_d         = 1'b1;
          end else if (chk_live) begin
            left_d = left_q + CntW'(1);
          end
        end

        if (pass_end) begin
          if (changed_q || hit) begin
            // another pass over the store
            idx_d     = '0;
            changed_d = 1'b0;
            left_d    = '0;
          end else begin
            state_d     = ST_IDLE;
            out_valid_d = 1'b1;
            untouched_d = UntouchW'(left_d);
            out_ovf_d   = ovf_q;
            known_d     = '0;
            live_d      = '0;
            count_d     = '0;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      known_q     <= '0;
      live_q      <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      chk_vld_q   <= 1'b0;
      changed_q   <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      known_q     <= known_d;
      live_q      <= live_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      idx_q       <= idx_d;
      chk_vld_q   <= chk_vld_d;
      changed_q   <= changed_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    chk_idx_q   <= chk_idx_d;
    untouched_q <= untouched_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o            = out_valid_q;
  assign out_untouched_groups_o = untouched_q;
  assign out_overflow_o         = out_ovf_q;

  // a sweep only starts with an empty result register
  a_sweep_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> !out_valid_q)
    else $error("result pending during sweep");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxGroups))
    else $error("group count beyond store depth");

  // check stage only ever looks at stored entries
  a_chk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> ((CntW'(chk_idx_q) < count_q) && (state_q == ST_SWEEP)))
    else $error("check stage outside stored groups");

  // a new result comes with the store and known set cleared
  a_clear_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ((count_q == '0) && (known_q == '0) && (live_q == '0)))
    else $error("state not cleared after finish");

endmodule

// ----- tb/seeded_group_reachability_count_test.sv -----
// ----------------------------------------------------------------------------
// seeded_group_reachability_count_test
// self-checking testbench: drives seed, group and finish words through the
// input channel, keeps its own copy of the known set and the group store to
// work out each finish result, and compares every result word field by field
// ----------------------------------------------------------------------------
module seeded_group_reachability_count_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sgrc_pkg::*;

  // op code that the block must ignore
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

  // people outside MAX_PEOPLE are dropped by the block
  localparam logic [MembersW-1:0] PEOPLE_MASK = {MembersW{1'b1}} >> (MembersW - MAX_PEOPLE);

  // cycles with nothing accepted on either side before giving up
  // the limit covers the longest finish sweep several times over
  localparam int unsigned STUCK_LIMIT = 20000;
  // quiet cycles after the last result, seed/group words settle at once
  localparam int unsigned TAIL_CYCLES = 20;
  // receiver hold-off for the fill test
  localparam int unsigned HOLD_CYCLES = 400;

  // one result word
  typedef struct packed {
    logic [UntouchW-1:0] untouched;
    logic                overflow;
  } tally_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [OpW-1:0]      in_op_i;
  logic [MembersW-1:0] in_members_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [UntouchW-1:0] out_untouched_groups_o;
  logic                out_overflow_o;

  seeded_group_reachability_count dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .in_op_i                (in_op_i),
    .in_members_i           (in_members_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .out_untouched_groups_o (out_untouched_groups_o),
    .out_overflow_o         (out_overflow_o)
  );

  // shadow of the block state
  logic [MembersW-1:0]   reach_set;
  logic [MembersW-1:0]   grp_mask [MAX_GROUPS];
  logic [MAX_GROUPS-1:0] grp_live;
  int unsigned           grp_cnt;
  logic                  ovf_seen;

  // finish results still owed by the block, oldest first
  tally_t tally_q [$];

  // idling knobs, percent per cycle
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  // long receiver hold-off request, picked up by the stall process
  int unsigned hold_request;

  // bookkeeping
  int unsigned words_sent;
  int unsigned tallies_checked;
  int unsigned tallies_with_left;
  int unsigned err_cnt;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------------
  // prediction: apply one accepted word to the shadow state, queue the
  // expected result on finish
  // ------------------------------------------------------------------------
  function automatic void apply_word(input logic [OpW-1:0] op,
                                     input logic [MembersW-1:0] m);
    logic [MembersW-1:0] pm;
    bit                  grew;
    int unsigned         left;
    int unsigned         g;
    tally_t              res;
    pm = m & PEOPLE_MASK;
    case (op)
      OP_SEED: begin
        reach_set |= pm;
      end
      OP_GROUP: begin
        // full store drops the group and latches overflow
        if (grp_cnt < MAX_GROUPS) begin
          grp_mask[grp_cnt] = pm;
          grp_live[grp_cnt] = 1'b1;
          grp_cnt++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      OP_FINISH: begin
        // sweep until a pass retires nothing
        grew = 1'b1;
        while (grew) begin
          grew = 1'b0;
          for (g = 0; g < grp_cnt; g++) begin
            if (grp_live[g] && ((grp_mask[g] & reach_set) != '0)) begin
              reach_set |= grp_mask[g];
              grp_live[g] = 1'b0;
              grew = 1'b1;
            end
          end
        end
        left = 0;
        for (g = 0; g < grp_cnt; g++) begin
          if (grp_live[g]) left++;
        end
        res.untouched = UntouchW'(left);
        res.overflow  = ovf_seen;
        tally_q = {tally_q, res};
        // overflow survives a finish, the rest is cleared
        reach_set = '0;
        grp_cnt   = 0;
        grp_live  = '0;
      end
      default: begin
        // unused op code: no effect
      end
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // input side: one word per call, called and returning at a rising edge
  // acceptance is decided from the stall seen at the falling edge before
  // ------------------------------------------------------------------------
  task automatic send_word(input logic [OpW-1:0] op, input logic [MembersW-1:0] m);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_op_i      <= op;
    in_members_i <= m;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    apply_word(op, m);
    words_sent++;
  endtask

  // mask picker: mostly a few people out of a small pool so that groups
  // chain into each other, sometimes empty, full or fully random
  function automatic logic [MembersW-1:0] pick_mask(input int unsigned pool);
    logic [MembersW-1:0] m;
    int unsigned         n;
    int unsigned         k;
    m = '0;
    case ($urandom_range(9))
      0: m = '0;
      1: m = '1;
      2, 3: m = {$urandom, $urandom};
      default: begin
        n = $urandom_range(3, 1);
        for (k = 0; k < n; k++) m[$urandom_range(pool - 1)] = 1'b1;
      end
    endcase
    return m;
  endfunction

  // one round: seeds and groups in random order, then a finish
  // with some noise words and the odd broken round thrown in
  task automatic random_round(output int unsigned sent);
    int unsigned pool;
    int unsigned n_seed;
    int unsigned n_grp;
    pool   = $urandom_range(64, 6);
    n_seed = $urandom_range(3);
    // now and then a large store, mostly small ones
    n_grp  = ($urandom_range(39) == 0) ? $urandom_range(MAX_GROUPS, 30) : $urandom_range(10);
    sent   = 0;
    while (n_seed + n_grp > 0) begin
      if (n_grp == 0 || (n_seed > 0 && $urandom_range(3) == 0)) begin
        send_word(OP_SEED, pick_mask(pool));
        n_seed--;
      end else begin
        send_word(OP_GROUP, pick_mask(pool));
        n_grp--;
      end
      sent++;
      // ignored words do not count
      if ($urandom_range(19) == 0) send_word(OP_UNUSED, {$urandom, $urandom});
    end
    send_word(OP_FINISH, {$urandom, $urandom});
    sent++;
    // back-to-back finish on an emptied store
    if ($urandom_range(11) == 0) begin
      send_word(OP_FINISH, {$urandom, $urandom});
      sent++;
    end
  endtask

  task automatic random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                              input int unsigned n_words);
    int unsigned total;
    int unsigned sent;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    total = 0;
    while (total < n_words) begin
      random_round(sent);
      total += sent;
    end
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // hand-built cases: empty finish, chained groups that need a second pass,
  // empty group, all-ones masks, ignored op code, clearing by finish
  task automatic test_directed;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // nothing stored at all
    send_word(OP_FINISH, '0);
    // chain: person 0 -> {0,1} -> {1,62} -> {62,63} on the next pass
    send_word(OP_SEED,  64'h1);
    send_word(OP_GROUP, 64'hC000_0000_0000_0000);
    send_word(OP_GROUP, 64'h3);
    send_word(OP_GROUP, 64'h4000_0000_0000_0002);
    send_word(OP_GROUP, '0);                      // empty group stays untouched
    send_word(OP_GROUP, 64'h0000_0100_0000_0000); // unrelated person
    send_word(OP_FINISH, '1);
    // everyone seeded, full group reached, empty one not
    send_word(OP_SEED,  '1);
    send_word(OP_GROUP, '1);
    send_word(OP_GROUP, '0);
    send_word(OP_FINISH, '0);
    // unused op code must not seed anyone
    send_word(OP_UNUSED, '1);
    send_word(OP_GROUP, 64'h80);
    send_word(OP_FINISH, '0);
    // seeds only
    send_word(OP_SEED,  64'h8);
    send_word(OP_FINISH, '0);
    // known set is cleared by finish
    send_word(OP_SEED,  64'h200);
    send_word(OP_FINISH, '0);
    send_word(OP_GROUP, 64'h200);
    send_word(OP_FINISH, '0);
    // group seeded later in the round still counts
    send_word(OP_GROUP, 64'h8000_0000_0000_0000);
    send_word(OP_SEED,  64'h8000_0000_0000_0000);
    send_word(OP_FINISH, '0);
  endtask

  task automatic test_random_traffic;
    random_phase(0, 0, 250);
    random_phase(84, 0, 250);
    random_phase(0, 84, 250);
    random_phase(15, 15, 250);
  endtask

  // receiver holds off while the sender keeps pushing finishes, so the
  // result register fills and the input side has to stall
  task automatic test_backpressure_fill;
    int unsigned r;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = HOLD_CYCLES;
    for (r = 0; r < 8; r++) begin
      send_word(OP_GROUP, pick_mask(8));
      send_word(OP_SEED,  pick_mask(8));
      send_word(OP_GROUP, pick_mask(8));
      send_word(OP_FINISH, '0);
    end
  endtask

  // full store built as a reverse chain so each pass retires one group,
  // one more group overflows, then overflow must stick through finish
  task automatic test_store_overflow;
    int unsigned g;
    send_idle_pct  = 0;
    recv_stall_pct = 30;
    send_word(OP_SEED, 64'h1);
    for (g = 0; g < MAX_GROUPS - 1; g++) begin
      send_word(OP_GROUP, 64'h3 << (MAX_GROUPS - 2 - g));
    end
    send_word(OP_GROUP, '0);
    send_word(OP_GROUP, '1);   // store full, dropped
    send_word(OP_FINISH, '0);
    send_word(OP_GROUP, 64'h4);
    send_word(OP_SEED,  64'h4);
    send_word(OP_FINISH, '0);
  endtask

  // ------------------------------------------------------------------------
  // receiver stall, with the long hold-off counted here
  // ------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // ------------------------------------------------------------------------
  // result checker: sampled mid-cycle, the word is taken at the next edge
  // ------------------------------------------------------------------------
  initial begin
    tally_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (tally_q.size() == 0) begin
          $error("result word with nothing expected: untouched_groups=%0d overflow=%0d",
                 out_untouched_groups_o, out_overflow_o);
          err_cnt++;
        end else begin
          want = tally_q.pop_front();
          if (out_untouched_groups_o !== want.untouched) begin
            $error("untouched_groups mismatch: expected %0d, actual %0d",
                   want.untouched, out_untouched_groups_o);
            err_cnt++;
          end
          if (out_overflow_o !== want.overflow) begin
            $error("overflow mismatch: expected %0b, actual %0b",
                   want.overflow, out_overflow_o);
            err_cnt++;
          end
          if (want.untouched != 0) tallies_with_left++;
          tallies_checked++;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // watchdog: cycles in a row with no word taken on either channel
  // ------------------------------------------------------------------------
  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(negedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $error("no progress for %0d cycles, %0d results outstanding", STUCK_LIMIT, tally_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    reach_set         = '0;
    grp_live          = '0;
    grp_cnt           = 0;
    ovf_seen          = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_request      = 0;
    words_sent        = 0;
    tallies_checked   = 0;
    tallies_with_left = 0;
    err_cnt           = 0;

    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    in_op_i      <= OP_SEED;
    in_members_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_traffic();
    test_backpressure_fill();
    test_store_overflow();
    in_valid_i <= 1'b0;

    // drain, the watchdog bounds this
    while (tally_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tally_q.size() != 0) begin
      $error("%0d expected results never arrived", tally_q.size());
      err_cnt++;
    end

    $display("covered: %0d words in, %0d finish results checked (%0d with groups left)",
             words_sent, tallies_checked, tallies_with_left);
    $display("covered: idle and stall mixes, receiver hold-off fill, full store and overflow");
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
